@@ sv/rrq_pkg.sv @@
`default_nettype none

package rrq_pkg;

	// Default sizing of the queue.
	localparam int QUEUE_DEPTH_DEF = 32;
	localparam int ID_BITS_DEF     = 8;

	// Fixed widths of the transaction fields.
	localparam int TASK_ID_W = 8;
	localparam int REQ_W     = 2;
	localparam int STATUS_W  = 3;
	localparam int OCC_W     = 6;

	// A tick only rotates when at least this many tasks are queued.
	localparam int RESCHED_MIN = 2;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_ENQ    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_PICK   = 2'd2;
	localparam logic [REQ_W-1:0] REQ_TICK   = 2'd3;

	// Status codes.
	localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_DUP       = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_PICK,
		S_FINISH,
		S_RESP
	} state_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic in_fire;
		logic is_pick;
		logic scan_done;
		logic out_fire;
	} fsm_in_t;

	// Controls from the sequencer to the datapath.
	typedef struct packed {
		logic in_ready;
		logic start;
		logic scan_en;
		logic pick_load;
		logic finish;
		logic out_valid;
	} fsm_ctl_t;

endpackage

`default_nettype wire

@@ sv/rrq_req_if.sv @@
`default_nettype none

interface rrq_req_if import rrq_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [REQ_W-1:0]     req_type;
	logic [TASK_ID_W-1:0] task_id;

	modport source (output valid, output req_type, output task_id, input ready);
	modport sink   (input valid, input req_type, input task_id, output ready);
endinterface

`default_nettype wire

@@ sv/rrq_rsp_if.sv @@
`default_nettype none

interface rrq_rsp_if import rrq_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [TASK_ID_W-1:0] picked_id;
	logic [STATUS_W-1:0]  status;
	logic                 resched;
	logic [OCC_W-1:0]     occupancy;

	modport source (output valid, output picked_id, output status, output resched,
		output occupancy, input ready);
	modport sink   (input valid, input picked_id, input status, input resched,
		input occupancy, output ready);
endinterface

`default_nettype wire

@@ sv/rrq_ram.sv @@
`default_nettype none

// Single write port, single registered read port.
module rrq_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ sv/rrq_fsm.sv @@
`default_nettype none

// Sequencer: accepts one request, runs the slot scan (or, for a pick, loads the head), then presents the result.
module rrq_fsm import rrq_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire fsm_in_t  sts,
	output fsm_ctl_t      ctl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (sts.in_fire) begin
					state_d = sts.is_pick ? S_PICK : S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.scan_done) begin
					state_d = S_FINISH;
				end
			end
			S_PICK:   state_d = S_RESP;
			S_FINISH: state_d = S_RESP;
			S_RESP: begin
				if (sts.out_fire) begin
					state_d = S_IDLE;
				end
			end
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			S_IDLE: begin
				ctl.in_ready = 1'b1;
				ctl.start    = sts.in_fire;
			end
			S_SCAN:   ctl.scan_en   = 1'b1;
			S_PICK:   ctl.pick_load = 1'b1;
			S_FINISH: ctl.finish    = 1'b1;
			S_RESP:   ctl.out_valid = 1'b1;
			default:  ctl = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ sv/round_robin_ready_queue.sv @@
`default_nettype none

// Channel  Port  Direction  Payload
// request  req   sink       req_type, task_id
// result   rsp   source     picked_id, status, resched, occupancy
//
// One request is taken at a time. A pick registers the head entry as its
// result; any other request scans the slot memory one entry per cycle, and a
// finish step then registers its result.
// The result is held until the sink takes it, and the next request is taken in
// the cycle after that at the earliest. Reset empties the queue at once; the
// slot memory is not cleared, as only entries below the fill count are read.
module round_robin_ready_queue import rrq_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int ID_BITS     = ID_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rrq_req_if.sink    req,
	rrq_rsp_if.source  rsp
);

	// Slot address width and the width of a count that can reach the depth.
	localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	fsm_in_t  sts;
	fsm_ctl_t ctl;

	// Queue state: the fill count, with slots held compact from the head.
	logic [CNT_W-1:0] count_q;

	// Request held for the duration of the transaction.
	logic [REQ_W-1:0]   req_q;
	logic [ID_BITS-1:0] id_q;

	// Scan state: the next slot to read, and the slot whose data is now on the
	// memory's read port.
	logic [CNT_W-1:0] iss_q;
	logic             rdv_s1;
	logic [AW-1:0]    raddr_s1;
	logic             found_q;

	// Result register.
	logic [TASK_ID_W-1:0] res_id_q;
	logic [STATUS_W-1:0]  res_status_q;
	logic                 res_resched_q;
	logic [OCC_W-1:0]     res_occ_q;

	// Memory port.
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [ID_BITS-1:0] ram_wdata;
	logic [AW-1:0]      ram_raddr;
	logic [ID_BITS-1:0] ram_rdata;

	logic             issue;
	logic             hit;
	logic             shift_req;
	logic             shift_we;
	logic             few_queued;
	logic [CNT_W-1:0] cnt_m1;

	// Outcome of the request, settled in the cycle after the scan.
	logic [STATUS_W-1:0] fin_status;
	logic                fin_resched;
	logic                fin_we;
	logic [AW-1:0]       fin_waddr;
	logic [CNT_W-1:0]    count_next;

	rrq_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	rrq_ram #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH (ID_BITS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// The scan reads one slot per cycle and compares it with the request id.
	// On a remove or a tick, every entry after the match is written back one
	// slot nearer the head as it goes by, so the gap closes in the same pass.
	always_comb begin
		issue      = ctl.scan_en && (iss_q != count_q);
		hit        = rdv_s1 && (ram_rdata == id_q);
		shift_req  = (req_q == REQ_REMOVE) || (req_q == REQ_TICK);
		shift_we   = ctl.scan_en && rdv_s1 && found_q && shift_req;
		few_queued = count_q < CNT_W'(RESCHED_MIN);
		cnt_m1     = count_q - CNT_W'(1);
	end

	assign sts.in_fire   = req.valid && ctl.in_ready;
	assign sts.is_pick   = req.req_type == REQ_PICK;
	assign sts.scan_done = !issue && !rdv_s1;
	assign sts.out_fire  = ctl.out_valid && rsp.ready;

	// Outcome of a non-pick request once the scan has told whether the id is
	// present.
	always_comb begin
		fin_status  = STAT_OK;
		fin_resched = 1'b0;
		fin_we      = 1'b0;
		fin_waddr   = count_q[AW-1:0];
		count_next  = count_q;
		unique case (req_q)
			REQ_ENQ: begin
				if (found_q) begin
					fin_status = STAT_DUP;
				end else if (count_q == CNT_W'(QUEUE_DEPTH)) begin
					fin_status = STAT_FULL;
				end else begin
					fin_we     = 1'b1;
					count_next = count_q + CNT_W'(1);
				end
			end
			REQ_REMOVE: begin
				if (!found_q) begin
					fin_status = STAT_NOT_FOUND;
				end else begin
					count_next = cnt_m1;
				end
			end
			REQ_TICK: begin
				// With fewer than two queued a tick is a no-op, found or not.
				if (!few_queued) begin
					if (!found_q) begin
						fin_status = STAT_NOT_FOUND;
					end else begin
						fin_we      = 1'b1;
						fin_waddr   = cnt_m1[AW-1:0];
						fin_resched = 1'b1;
					end
				end
			end
			default: begin
				fin_status = STAT_OK;
			end
		endcase
	end

	// The read port rests on the head slot, so a pick finds the head on the
	// port in the cycle after acceptance.
	always_comb begin
		ram_raddr = issue ? iss_q[AW-1:0] : '0;
		if (ctl.finish) begin
			ram_we    = fin_we;
			ram_waddr = fin_waddr;
			ram_wdata = id_q;
		end else begin
			ram_we    = shift_we;
			ram_waddr = raddr_s1 - AW'(1);
			ram_wdata = ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			iss_q   <= '0;
			rdv_s1  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			if (ctl.start) begin
				iss_q   <= '0;
				rdv_s1  <= 1'b0;
				found_q <= 1'b0;
			end else begin
				if (issue) begin
					iss_q <= iss_q + CNT_W'(1);
				end
				rdv_s1 <= issue;
				if (hit) begin
					found_q <= 1'b1;
				end
			end
			if (ctl.finish) begin
				count_q <= count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			req_q <= req.req_type;
			id_q  <= ID_BITS'(req.task_id);
		end
		raddr_s1 <= iss_q[AW-1:0];
		if (ctl.pick_load) begin
			res_id_q      <= (count_q == '0) ? '0 : TASK_ID_W'(ram_rdata);
			res_status_q  <= (count_q == '0) ? STAT_EMPTY : STAT_OK;
			res_resched_q <= 1'b0;
			res_occ_q     <= OCC_W'(count_q);
		end else if (ctl.finish) begin
			res_id_q      <= TASK_ID_W'(id_q);
			res_status_q  <= fin_status;
			res_resched_q <= fin_resched;
			res_occ_q     <= OCC_W'(count_next);
		end
	end

	assign req.ready     = ctl.in_ready;
	assign rsp.valid     = ctl.out_valid;
	assign rsp.picked_id = res_id_q;
	assign rsp.status    = res_status_q;
	assign rsp.resched   = res_resched_q;
	assign rsp.occupancy = res_occ_q;

	// The fill count never passes the depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("fill count above queue depth");

	// A request is never taken while a result is still on offer.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && rsp.valid))
		else $error("request accepted while a result is pending");

	// The fill count moves only at the end of a scan.
	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> $past(ctl.finish))
		else $error("fill count changed outside the finish step");

	// A reschedule is only ever reported together with a good status.
	a_resched_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.resched) |-> (rsp.status == STAT_OK))
		else $error("reschedule reported with an error status");

endmodule

`default_nettype wire
